// ===== hw/rtl/grld_pkg.sv =====
// Shared types and constants of the run-length decoder.
`default_nettype none

package grld_pkg;

  localparam int unsigned ByteW  = 7;
  localparam int unsigned CountW = 2;

  localparam logic [ByteW-1:0]  RunMark     = 7'd42;  // '*'
  localparam logic [ByteW-1:0]  CountOffset = 7'd29;
  localparam logic [CountW-1:0] CntNone     = 2'd0;
  localparam logic [CountW-1:0] CntOne      = 2'd1;
  localparam logic [CountW-1:0] CntTwo      = 2'd2;

  typedef struct packed {
    logic [ByteW-1:0] in_byte;
    logic             packet_end;
  } in_item_t;

  typedef struct packed {
    logic [ByteW-1:0]  byte_a;
    logic [ByteW-1:0]  byte_b;
    logic [CountW-1:0] byte_count;
    logic              decode_error;
    logic              packet_done;
    logic              run_last;
  } out_item_t;

  typedef struct packed {
    logic load;  // take the input item
    logic emit;  // push the next run chunk to the output register
  } grld_cmd_t;

  typedef struct packed {
    logic out_free;    // output register empty or being taken this cycle
    logic run_start;   // the offered item opens a run
    logic chunk_last;  // at most two run bytes remain
  } grld_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/gdb_run_length_decoder.sv =====
// Top level of the debugger-protocol run-length decoder.
// Takes one 7-bit payload character per item and gives decoded bytes up to two to a
// result. A plain character, or a packet end with nothing else to show, is
// taken and gives one result. A star or a bad count is taken and gives no
// result. A count character opening a run of N bytes (N up to 98) is
// followed by the run chunks: the output register carries up to two run bytes
// a cycle while the output is not stalled, and input is stalled meanwhile.
// Input is taken while a finished result waits, as long as the output
// register is being freed in that cycle.
`default_nettype none

module gdb_run_length_decoder (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  grld_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output grld_pkg::out_item_t out_data_o
);
  import grld_pkg::*;

  grld_cmd_t    cmd;
  grld_status_t status;

  grld_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  grld_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/grld_ctrl.sv =====
// Controller of the run-length decoder: accepts items and sequences run output.
`default_nettype none

module grld_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  grld_pkg::grld_status_t status_i,
  output grld_pkg::grld_cmd_t    cmd_o
);
  import grld_pkg::*;

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StRun  = 2'b10
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      StIdle: begin
        in_stall_o = !status_i.out_free;
        cmd_o.load = in_valid_i && status_i.out_free;
        if (cmd_o.load && status_i.run_start) begin
          state_d = StRun;
        end
      end
      StRun: begin
        cmd_o.emit = status_i.out_free;
        if (cmd_o.emit && status_i.chunk_last) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/grld_dp.sv =====
// Datapath of the run-length decoder: packet state, run counter, output register.
`default_nettype none

module grld_dp (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  grld_pkg::in_item_t     in_data_i,
  input  grld_pkg::grld_cmd_t    cmd_i,
  output grld_pkg::grld_status_t status_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output grld_pkg::out_item_t    out_data_o
);
  import grld_pkg::*;

  logic [ByteW-1:0] prev_q, prev_d;
  logic             have_prev_q, have_prev_d;
  logic             run_pend_q, run_pend_d;
  logic             err_q, err_d;
  logic [ByteW-1:0] run_byte_q;
  logic [ByteW-1:0] left_q;
  logic             end_q;
  logic             out_valid_q;
  out_item_t        out_q;

  logic             is_mark;
  logic             is_plain;
  logic             single;
  logic             chunk_two;
  logic [CountW-1:0] chunk_cnt;

  assign is_mark   = (in_data_i.in_byte == RunMark);
  assign is_plain  = !err_q && !is_mark && !run_pend_q;
  // plain character, or packet end with nothing else to show
  assign single    = is_plain || (in_data_i.packet_end && !status_o.run_start);
  assign chunk_two = (left_q >= 7'd2);
  assign chunk_cnt = chunk_two ? CntTwo : CntOne;

  assign status_o.out_free   = !out_valid_q || !out_stall_i;
  assign status_o.run_start  = !err_q && !is_mark && run_pend_q &&
                               (in_data_i.in_byte > CountOffset);
  assign status_o.chunk_last = (left_q <= 7'd2);

  always_comb begin
    prev_d      = prev_q;
    have_prev_d = have_prev_q;
    run_pend_d  = run_pend_q;
    err_d       = err_q;
    if (!err_q) begin
      if (is_mark) begin
        if (!have_prev_q) begin
          err_d = 1'b1;
        end else begin
          if (run_pend_q) begin
            prev_d = RunMark;  // star after star
          end
          run_pend_d = 1'b1;
        end
        have_prev_d = 1'b1;
      end else begin
        if (run_pend_q && (in_data_i.in_byte <= CountOffset)) begin
          err_d = 1'b1;
        end
        run_pend_d  = 1'b0;
        prev_d      = in_data_i.in_byte;
        have_prev_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '0;
      have_prev_q <= 1'b0;
      run_pend_q  <= 1'b0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        prev_q <= prev_d;
        if (in_data_i.packet_end) begin
          have_prev_q <= 1'b0;
          run_pend_q  <= 1'b0;
          err_q       <= 1'b0;
        end else begin
          have_prev_q <= have_prev_d;
          run_pend_q  <= run_pend_d;
          err_q       <= err_d;
        end
      end
      if ((cmd_i.load && single) || cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // run registers and output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && status_o.run_start) begin
      run_byte_q <= prev_q;
      left_q     <= in_data_i.in_byte - CountOffset;
      end_q      <= in_data_i.packet_end;
    end else if (cmd_i.emit) begin
      left_q <= left_q - {{(ByteW-CountW){1'b0}}, chunk_cnt};
    end

    if (cmd_i.load && single) begin
      out_q.byte_a       <= is_plain ? in_data_i.in_byte : '0;
      out_q.byte_b       <= '0;
      out_q.byte_count   <= is_plain ? CntOne : CntNone;
      out_q.decode_error <= in_data_i.packet_end && err_d;
      out_q.packet_done  <= in_data_i.packet_end;
      out_q.run_last     <= 1'b1;
    end else if (cmd_i.emit) begin
      out_q.byte_a       <= run_byte_q;
      out_q.byte_b       <= chunk_two ? run_byte_q : '0;
      out_q.byte_count   <= chunk_cnt;
      out_q.decode_error <= 1'b0;  // a run only starts on a clean packet
      out_q.packet_done  <= end_q && status_o.chunk_last;
      out_q.run_last     <= status_o.chunk_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_emit_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (left_q != '0))
    else $error("run chunk emitted with no bytes left");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load || cmd_i.emit) |-> !(out_valid_q && out_stall_i))
    else $error("output register overwritten while stalled");

  a_run_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load && status_o.run_start) |=> (!out_valid_q && left_q != '0))
    else $error("run start left bad counter or output state");

endmodule

`default_nettype wire

// ===== bench/grld_checker.sv =====
// Channel monitor for the run-length decoder: predicts decoded results and compares them.
`timescale 1ns / 100ps

module grld_checker
  import grld_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_item_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_item_t out_data_i,
  output int        pending_o,
  output int        fail_count_o,
  output int        checked_o,
  output int        runs_o
);

  // decoder state as seen by the prediction
  logic [ByteW-1:0] run_byte;
  logic             seen_char;
  logic             star_open;
  logic             bad_pkt;

  out_item_t decoded_q[$];
  int        fails;
  int        checked;
  int        runs;

  function automatic out_item_t make_res(input logic [ByteW-1:0] a, input logic [ByteW-1:0] b,
                                         input logic [CountW-1:0] cnt);
    out_item_t r;
    r              = '0;
    r.byte_a       = a;
    r.byte_b       = b;
    r.byte_count   = cnt;
    return r;
  endfunction

  task automatic expand_char(input in_item_t it);
    out_item_t        res[$];
    out_item_t        r;
    logic [ByteW-1:0] ch;
    int unsigned      left;
    ch = it.in_byte;
    if (!bad_pkt) begin
      if (ch == RunMark) begin
        if (!seen_char) begin
          bad_pkt = 1'b1;
        end else begin
          // star after star: the star itself becomes the run byte
          if (star_open) run_byte = RunMark;
          star_open = 1'b1;
        end
        seen_char = 1'b1;
      end else if (star_open) begin
        if (ch <= CountOffset) begin
          bad_pkt = 1'b1;
        end else begin
          left = int'(ch) - int'(CountOffset);
          while (left >= 2) begin
            res.push_back(make_res(run_byte, run_byte, CntTwo));
            left -= 2;
          end
          if (left == 1) res.push_back(make_res(run_byte, '0, CntOne));
          runs++;
        end
        star_open = 1'b0;
        run_byte  = ch;
        seen_char = 1'b1;
      end else begin
        res.push_back(make_res(ch, '0, CntOne));
        run_byte  = ch;
        seen_char = 1'b1;
      end
    end
    if (it.packet_end && res.size() == 0) res.push_back(make_res('0, '0, CntNone));
    if (res.size() > 0) begin
      r          = res[res.size()-1];
      r.run_last = 1'b1;
      if (it.packet_end) begin
        r.decode_error = bad_pkt;
        r.packet_done  = 1'b1;
      end
      res[res.size()-1] = r;
    end
    if (it.packet_end) begin
      seen_char = 1'b0;
      star_open = 1'b0;
      bad_pkt   = 1'b0;
    end
    foreach (res[k]) decoded_q.push_back(res[k]);
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      fails++;
    end
  endtask

  task automatic compare_result(input out_item_t got);
    out_item_t want;
    if (decoded_q.size() == 0) begin
      $display("%0t: unexpected result, expected none, got %p", $time, got);
      fails++;
    end else begin
      want = decoded_q.pop_front();
      check_field("byte_a", 32'(want.byte_a), 32'(got.byte_a));
      check_field("byte_b", 32'(want.byte_b), 32'(got.byte_b));
      check_field("byte_count", 32'(want.byte_count), 32'(got.byte_count));
      check_field("decode_error", 32'(want.decode_error), 32'(got.decode_error));
      check_field("packet_done", 32'(want.packet_done), 32'(got.packet_done));
      check_field("run_last", 32'(want.run_last), 32'(got.run_last));
      checked++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_byte  = '0;
      seen_char = 1'b0;
      star_open = 1'b0;
      bad_pkt   = 1'b0;
      decoded_q.delete();
      fails     = 0;
      checked   = 0;
      runs      = 0;
    end else begin
      // output first: a result can never stem from the item taken at this same edge
      if (out_valid_i && !out_stall_i) compare_result(out_data_i);
      if (in_valid_i && !in_stall_i) expand_char(in_data_i);
    end
    pending_o    <= decoded_q.size();
    fail_count_o <= fails;
    checked_o    <= checked;
    runs_o       <= runs;
  end

endmodule

// ===== bench/testbench.sv =====
// Top of the run-length decoder bench: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 100ps

module testbench;
  import grld_pkg::*;

  localparam int StallLimit  = 2000;
  localparam int RandomChars = 350;
  localparam int TailCycles  = 60;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;

  int pending;
  int fail_count;
  int checked;
  int runs;
  int gap_pct      = 17;
  int stall_pct    = 17;
  int chars_sent   = 0;
  int packets_sent = 0;
  int quiet_cycles = 0;

  gdb_run_length_decoder i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  grld_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_i  (out_data_o),
    .pending_o   (pending),
    .fail_count_o(fail_count),
    .checked_o   (checked),
    .runs_o      (runs)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // watchdog: cycles with neither channel moving an item
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("%0t: no progress for %0d cycles", $time, StallLimit);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_char(input logic [ByteW-1:0] ch, input logic last);
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{in_byte: ch, packet_end: last};
    do @(posedge clk_i); while (in_stall_o);
    chars_sent++;
    if (last) packets_sent++;
  endtask

  // hold the sender until every predicted result has been taken
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic send_random_packet();
    logic [ByteW-1:0] pkt[$];
    logic [ByteW-1:0] ch;
    int               len;
    int               roll;
    len = $urandom_range(1, 8);
    for (int k = 0; k < len; k++) begin
      roll = $urandom_range(99);
      if (roll < 8) begin
        pkt.push_back(ByteW'($urandom_range(127)));
      end else if (roll < 35 && pkt.size() > 0) begin
        pkt.push_back(RunMark);
        roll = $urandom_range(99);
        if (roll < 5)       pkt.push_back(ByteW'($urandom_range(29)));
        else if (roll < 18) pkt.push_back(ByteW'($urandom_range(127, 30)));
        else if (roll >= 24) pkt.push_back(ByteW'($urandom_range(45, 30)));
        // otherwise the star is left open for whatever follows
      end else begin
        do ch = ByteW'($urandom_range(127)); while (ch == RunMark);
        pkt.push_back(ch);
      end
    end
    foreach (pkt[k]) send_char(pkt[k], k == pkt.size() - 1);
  endtask

  initial begin
    int  target;
    bit  paused;
    paused = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // star at packet start, alone and with trailing bytes dropped
    send_char(RunMark, 1'b1);
    send_char(RunMark, 1'b0);
    send_char(7'd65, 1'b0);
    send_char(7'd66, 1'b1);
    // zero byte, top byte, longest run
    send_char(7'd0, 1'b0);
    send_char(7'd127, 1'b0);
    send_char(RunMark, 1'b0);
    send_char(7'd127, 1'b0);
    // shortest runs: one and two copies
    send_char(7'd88, 1'b0);
    send_char(RunMark, 1'b0);
    send_char(7'd30, 1'b0);
    send_char(RunMark, 1'b0);
    send_char(7'd31, 1'b0);
    // star after star
    send_char(7'd97, 1'b0);
    send_char(RunMark, 1'b0);
    send_char(RunMark, 1'b0);
    send_char(7'd40, 1'b0);
    // packet closing on an open star
    send_char(7'd98, 1'b0);
    send_char(RunMark, 1'b1);
    // count below the offset, then a dropped byte at the end
    send_char(7'd99, 1'b0);
    send_char(RunMark, 1'b0);
    send_char(7'd0, 1'b0);
    send_char(7'd100, 1'b1);
    // count of exactly the offset, on the last byte
    send_char(7'd101, 1'b0);
    send_char(RunMark, 1'b0);
    send_char(CountOffset, 1'b1);
    drain_results();

    target = chars_sent + RandomChars;
    while (chars_sent < target) begin
      if (chars_sent >= 120 && chars_sent < 200) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = 17;
        stall_pct = 17;
      end
      if (!paused && chars_sent >= 250) begin
        drain_results();
        paused = 1'b1;
      end
      send_random_packet();
    end

    stall_pct = 17;
    drain_results();
    repeat (TailCycles) @(posedge clk_i);

    $display("Sent %0d characters in %0d packets: corner cases, random runs, bad counts.",
             chars_sent, packets_sent);
    $display("Checked %0d decoded results from %0d runs.", checked, runs);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d results still expected", fail_count, pending);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/grld_pkg.sv
hw/rtl/grld_ctrl.sv
hw/rtl/grld_dp.sv
hw/rtl/gdb_run_length_decoder.sv
bench/grld_checker.sv
bench/testbench.sv
